// ===== rtl/spq_pkg.sv =====
package spq_pkg;

    localparam int DEPTH          = 16;
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int ID_W           = 16;
    localparam int PRIO_W         = 8;
    localparam int OCC_W          = 5;
    localparam logic [ID_W-1:0] FIRST_ID_RESET = ID_W'(100);

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_DRAIN   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_INSERT,
        DP_POP,
        DP_FULL,
        DP_EMPTY
    } t_dp_op;

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } t_state;

    typedef struct packed {
        t_dp_op op;
        logic   last;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic one_left;
    } t_dp_stat;

endpackage

// ===== rtl/spq_datapath.sv =====
module spq_datapath
    import spq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [ID_W-1:0]    i_cfg_wr_data,
    input  logic [PRIO_W-1:0]  i_priority_req,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    output logic [1:0]         o_status,
    output logic [ID_W-1:0]    o_entry_id,
    output logic [PRIO_W-1:0]  o_entry_priority,
    output logic [OCC_W-1:0]   o_occupancy,
    output logic               o_last
);

    // row of cells, front at index 0
    logic [PRIO_W-1:0] r_prio [DEPTH];
    logic [ID_W-1:0]   r_id   [DEPTH];
    logic [PRIO_W-1:0] n_prio [DEPTH];
    logic [ID_W-1:0]   n_id   [DEPTH];
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ID_W-1:0]   r_next_id, n_next_id;

    t_status           r_status, n_status;
    logic [ID_W-1:0]   r_out_id, n_out_id;
    logic [PRIO_W-1:0] r_out_prio, n_out_prio;
    logic [OCC_W-1:0]  r_out_occ, n_out_occ;
    logic              r_out_last, n_out_last;

    logic [DEPTH-1:0]  mark;

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == CNT_W'(DEPTH));
    assign o_stat.one_left = (r_count == CNT_W'(1));

    // a cell is marked when it lies at or behind the insertion point
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            mark[i] = (CNT_W'(i) >= r_count) || (r_prio[i] > i_priority_req);
        end
    end

    always_comb begin
        n_prio     = r_prio;
        n_id       = r_id;
        n_count    = r_count;
        n_next_id  = r_next_id;
        n_status   = r_status;
        n_out_id   = r_out_id;
        n_out_prio = r_out_prio;
        n_out_occ  = r_out_occ;
        n_out_last = r_out_last;

        unique case (i_cmd.op)
            DP_INSERT: begin
                if (mark[0]) begin
                    n_prio[0] = i_priority_req;
                    n_id[0]   = r_next_id;
                end
                for (int i = 1; i < DEPTH; i++) begin
                    if (mark[i]) begin
                        n_prio[i] = mark[i-1] ? r_prio[i-1] : i_priority_req;
                        n_id[i]   = mark[i-1] ? r_id[i-1]   : r_next_id;
                    end
                end
                n_count    = r_count + CNT_W'(1);
                n_next_id  = r_next_id + ID_W'(1);
                n_status   = ST_OK;
                n_out_id   = r_next_id;
                n_out_prio = i_priority_req;
                n_out_occ  = OCC_W'(r_count + CNT_W'(1));
                n_out_last = i_cmd.last;
            end
            DP_POP: begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                    n_prio[i] = r_prio[i+1];
                    n_id[i]   = r_id[i+1];
                end
                n_count    = r_count - CNT_W'(1);
                n_status   = ST_OK;
                n_out_id   = r_id[0];
                n_out_prio = r_prio[0];
                n_out_occ  = OCC_W'(r_count - CNT_W'(1));
                n_out_last = i_cmd.last;
            end
            DP_FULL: begin
                n_status   = ST_FULL;
                n_out_id   = '0;
                n_out_prio = '0;
                n_out_occ  = OCC_W'(r_count);
                n_out_last = 1'b1;
            end
            DP_EMPTY: begin
                n_status   = ST_EMPTY;
                n_out_id   = '0;
                n_out_prio = '0;
                n_out_occ  = '0;
                n_out_last = 1'b1;
            end
            default: begin
            end
        endcase

        if (i_cfg_wr_en) begin
            n_next_id = i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_next_id <= FIRST_ID_RESET;
        end else begin
            r_count   <= n_count;
            r_next_id <= n_next_id;
        end
        r_prio     <= n_prio;
        r_id       <= n_id;
        r_status   <= n_status;
        r_out_id   <= n_out_id;
        r_out_prio <= n_out_prio;
        r_out_occ  <= n_out_occ;
        r_out_last <= n_out_last;
    end

    assign o_status         = r_status;
    assign o_entry_id       = r_out_id;
    assign o_entry_priority = r_out_prio;
    assign o_occupancy      = r_out_occ;
    assign o_last           = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> i_cmd.op != DP_INSERT)
        else $error("insert into a full row");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> i_cmd.op != DP_POP)
        else $error("pop from an empty row");

endmodule

// ===== rtl/spq_ctrl.sv =====
module spq_ctrl
    import spq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    input  t_dp_stat    i_stat,
    output t_dp_cmd     o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = DP_NONE;
        o_cmd.last = 1'b1;
        o_in_stall = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                o_in_stall = !out_free;
                if (i_in_valid && out_free) begin
                    unique case (t_cmd'(i_command))
                        CMD_ENQUEUE: begin
                            o_cmd.op = i_stat.full ? DP_FULL : DP_INSERT;
                        end
                        CMD_DEQUEUE: begin
                            o_cmd.op = i_stat.empty ? DP_EMPTY : DP_POP;
                        end
                        CMD_DRAIN: begin
                            if (i_stat.empty) begin
                                o_cmd.op = DP_EMPTY;
                            end else begin
                                o_cmd.op   = DP_POP;
                                o_cmd.last = i_stat.one_left;
                                if (!i_stat.one_left) begin
                                    n_state = S_DRAIN;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    o_cmd.op   = DP_POP;
                    o_cmd.last = i_stat.one_left;
                    if (i_stat.one_left) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = (o_cmd.op != DP_NONE) ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_drain_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DRAIN |-> !i_stat.empty)
        else $error("drain running on an empty queue");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op != DP_NONE |-> out_free)
        else $error("result overwritten while held");

    a_drain_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && out_free && i_stat.one_left) |=> r_state == S_IDLE)
        else $error("drain did not finish on its last entry");

    a_stall_outside_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DRAIN |-> o_in_stall)
        else $error("input taken during drain");

endmodule

// ===== rtl/stable_priority_queue.sv =====
// Stable priority queue of up to 16 entries; lower priority value is more urgent,
// equal priorities leave in arrival order.
// Input channel: i_in_valid / o_in_stall carry a beat of i_command and
// i_priority_req. Output channel: o_out_valid / i_out_stall carry a result
// beat (status, id, priority, occupancy, last).
// Enqueue, dequeue and an empty or full reply give one result, registered in
// the cycle after the input beat. Drain gives one result per held entry, one a
// cycle while the receiver does not stall, o_last on the final one; the input
// is stalled until the drain has handed its last result to the output register.
// Command value 3 is taken and gives no result.
// Throughput: one command per cycle while no drain runs and the output is taken
// each cycle; the shift-insert cell row inserts or removes one entry per cycle.
// A single output register holds a result while i_out_stall is high; a new
// beat is accepted in idle whenever that register is empty or being taken.
// i_cfg_wr_en with i_cfg_wr_data sets the identifier of the next enqueued
// entry; write only while the queue is idle.
// Reset (synchronous, i_rst_n low) empties the queue, clears o_out_valid and
// sets the next identifier to 100.
module stable_priority_queue
    import spq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [ID_W-1:0]    i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic [PRIO_W-1:0]  i_priority_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [ID_W-1:0]    o_entry_id,
    output logic [PRIO_W-1:0]  o_entry_priority,
    output logic [OCC_W-1:0]   o_occupancy,
    output logic               o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    spq_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_priority_req   (i_priority_req),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .o_status         (o_status),
        .o_entry_id       (o_entry_id),
        .o_entry_priority (o_entry_priority),
        .o_occupancy      (o_occupancy),
        .o_last           (o_last)
    );

endmodule

// ===== verif/stable_priority_queue_tb.sv =====
`timescale 1ns / 100ps

module stable_priority_queue_tb
    import spq_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         LIMIT_CYCLES = 400000;
    localparam int         MAX_REPORTS  = 10;

    typedef struct {
        logic [1:0]        status;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [OCC_W-1:0]  occ;
        logic              last;
    } t_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [ID_W-1:0]   i_cfg_wr_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_command;
    logic [PRIO_W-1:0] i_priority_req;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [1:0]        o_status;
    logic [ID_W-1:0]   o_entry_id;
    logic [PRIO_W-1:0] o_entry_priority;
    logic [OCC_W-1:0]  o_occupancy;
    logic              o_last;

    // shadow of the held entries, front at index 0
    logic [PRIO_W-1:0] shadow_prio [DEPTH];
    logic [ID_W-1:0]   shadow_id   [DEPTH];
    int                shadow_count;
    logic [ID_W-1:0]   shadow_next_id;
    t_result           awaited [$];

    int cycles;
    int mismatches;
    int n_results;
    int n_drained;
    int n_full;
    int n_empty;
    int n_in_stalls;
    bit tx_gaps;
    bit rx_gaps;
    int hold_cycles;

    stable_priority_queue i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_priority_req   (i_priority_req),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_entry_id       (o_entry_id),
        .o_entry_priority (o_entry_priority),
        .o_occupancy      (o_occupancy),
        .o_last           (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycles, awaited.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) begin
            return 0;
        end else if (r < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [PRIO_W-1:0] pick_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return PRIO_W'($urandom_range(0, 3));
        end else if (r < 60) begin
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        end
        return PRIO_W'($urandom);
    endfunction

    function automatic void push_result(logic [1:0] status, logic [ID_W-1:0] id,
                                        logic [PRIO_W-1:0] prio, logic last);
        t_result r;
        r.status = status;
        r.id     = id;
        r.prio   = prio;
        r.occ    = OCC_W'(shadow_count);
        r.last   = last;
        awaited.push_back(r);
    endfunction

    function automatic void take_front(output logic [ID_W-1:0] id,
                                       output logic [PRIO_W-1:0] prio);
        id   = shadow_id[0];
        prio = shadow_prio[0];
        for (int i = 1; i < shadow_count; i++) begin
            shadow_id[i-1]   = shadow_id[i];
            shadow_prio[i-1] = shadow_prio[i];
        end
        shadow_count--;
    endfunction

    function automatic void queue_step(logic [1:0] cmd, logic [PRIO_W-1:0] prio);
        int                pos;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] p;
        case (cmd)
            CMD_ENQUEUE: begin
                if (shadow_count >= DEPTH) begin
                    push_result(ST_FULL, '0, '0, 1'b1);
                end else begin
                    pos = 0;
                    while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_id[i]   = shadow_id[i-1];
                        shadow_prio[i] = shadow_prio[i-1];
                    end
                    shadow_id[pos]   = shadow_next_id;
                    shadow_prio[pos] = prio;
                    shadow_count++;
                    push_result(ST_OK, shadow_next_id, prio, 1'b1);
                    shadow_next_id = shadow_next_id + 1'b1;
                end
            end
            CMD_DEQUEUE, CMD_DRAIN: begin
                if (shadow_count == 0) begin
                    push_result(ST_EMPTY, '0, '0, 1'b1);
                end else if (cmd == CMD_DEQUEUE) begin
                    take_front(id, p);
                    push_result(ST_OK, id, p, 1'b1);
                end else begin
                    while (shadow_count > 0) begin
                        take_front(id, p);
                        push_result(ST_OK, id, p, shadow_count == 0);
                        n_drained++;
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_beat(logic [1:0] cmd, logic [PRIO_W-1:0] prio);
        int gap;
        @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_command      = cmd;
        i_priority_req = prio;
        @(posedge i_clk);
        while (o_in_stall) begin
            n_in_stalls++;
            @(posedge i_clk);
        end
        queue_step(cmd, prio);
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_first_id(logic [ID_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        shadow_next_id = value;
    endtask

    task automatic random_beat(int enq_pct);
        int         r;
        logic [1:0] cmd;
        r = $urandom_range(0, 99);
        if (r < enq_pct) begin
            cmd = CMD_ENQUEUE;
        end else if (r < 90) begin
            cmd = CMD_DEQUEUE;
        end else if (r < 95) begin
            cmd = CMD_DRAIN;
        end else begin
            cmd = CMD_UNUSED;
        end
        send_beat(cmd, pick_prio());
    endtask

    // empty replies, unused command, extreme priorities, ties
    task automatic test_empty_and_extremes();
        send_beat(CMD_DEQUEUE, 8'd7);
        send_beat(CMD_DRAIN, 8'd0);
        send_beat(CMD_UNUSED, 8'hFF);
        send_beat(CMD_ENQUEUE, 8'hFF);
        send_beat(CMD_ENQUEUE, 8'h00);
        send_beat(CMD_ENQUEUE, 8'hFF);
        send_beat(CMD_DEQUEUE, 8'h00);
        send_beat(CMD_DRAIN, 8'h00);
    endtask

    // fill to the brim across the identifier wrap, reject one, drain all
    task automatic test_fill_and_wrap();
        write_first_id(16'hFFFE);
        for (int i = 0; i < DEPTH; i++) begin
            send_beat(CMD_ENQUEUE, PRIO_W'((i * 5) % 4));
        end
        send_beat(CMD_ENQUEUE, 8'h00);
        send_beat(CMD_DRAIN, 8'h00);
    endtask

    // receiver holds off while beats keep coming, so the input backs up
    task automatic test_backpressure();
        tx_gaps     = 1'b0;
        hold_cycles = 150;
        wait (hold_cycles == 0);
        repeat (20) random_beat(75);
        tx_gaps = 1'b1;
    endtask

    task automatic test_random_phases();
        logic [ID_W-1:0] ids [5];
        int              enq_pct [5];
        ids     = '{16'h0000, 16'hFFFF, ID_W'($urandom), 16'hFFF0, ID_W'($urandom)};
        enq_pct = '{70, 85, 50, 80, 60};
        for (int ph = 0; ph < 5; ph++) begin
            write_first_id(ids[ph]);
            tx_gaps = (ph != 0);
            rx_gaps = (ph != 0);
            repeat (26) random_beat(enq_pct[ph]);
        end
    endtask

    initial begin
        int len;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                len         = hold_cycles;
                hold_cycles = 0;
            end else if (rx_gaps) begin
                len = pick_gap();
            end else begin
                len = 0;
            end
            i_out_stall = (len > 0);
            if (len > 1) repeat (len - 1) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected beat st=%0d id=%0d pr=%0d occ=%0d last=%0d",
                             $time, o_status, o_entry_id, o_entry_priority,
                             o_occupancy, o_last);
                end
            end else begin
                e = awaited.pop_front();
                if (e.status == ST_FULL) n_full++;
                if (e.status == ST_EMPTY) n_empty++;
                if (o_status !== e.status || o_entry_id !== e.id ||
                    o_entry_priority !== e.prio || o_occupancy !== e.occ ||
                    o_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: st=%0d id=%0d pr=%0d occ=%0d last=%0d",
                                 $time, o_status, o_entry_id, o_entry_priority,
                                 o_occupancy, o_last);
                        $display("    exp st=%0d id=%0d pr=%0d occ=%0d last=%0d",
                                 e.status, e.id, e.prio, e.occ, e.last);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        i_in_valid     = 1'b0;
        i_command      = CMD_ENQUEUE;
        i_priority_req = '0;
        tx_gaps        = 1'b0;
        rx_gaps        = 1'b0;
        hold_cycles    = 0;
        shadow_count   = 0;
        shadow_next_id = FIRST_ID_RESET;
        mismatches     = 0;
        n_results      = 0;
        n_drained      = 0;
        n_full         = 0;
        n_empty        = 0;
        n_in_stalls    = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        test_empty_and_extremes();
        test_fill_and_wrap();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Checked %0d result beats: %0d from drains, %0d empty and %0d full replies.",
                 n_results, n_drained, n_empty, n_full);
        $display("Input held off for %0d cycles; %0d mismatches in %0d cycles.",
                 n_in_stalls, mismatches, cycles);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
